// ----- src/rgb_to_hsl_converter_defines.svh -----
// Assertion macros for the RGB to HSL converter.
// Used by the top level; expects clk and rst_n in scope.
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

// same-cycle implication
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rhc_pkg.sv -----
// Shared types and constants of the RGB to HSL converter.
// No dependencies; used by every module of the block.
`default_nettype none

package rhc_pkg;

    localparam int unsigned CHANNEL_BITS  = 8;
    localparam int unsigned HUE_FRAC_BITS = 6;
    localparam int unsigned ALPHA_W       = 8;
    localparam int unsigned FIELD_W       = 15;

    localparam int unsigned CH_FULL = (1 << CHANNEL_BITS) - 1;
    localparam int unsigned SUM_W   = CHANNEL_BITS + 1;
    localparam int unsigned T_W     = CHANNEL_BITS + 3;

    // numerators are 2*x*scale + divisor, divisor of the rounded quotient is 2*D
    localparam int unsigned HUE_TURN        = 360 << HUE_FRAC_BITS;
    localparam int unsigned HUE_NUM_SCALE   = 2 * (60 << HUE_FRAC_BITS);
    localparam int unsigned SAT_NUM_SCALE   = 2 * 25600;
    localparam int unsigned LIGHT_NUM_SCALE = 2 * 12800;
    localparam int unsigned PCT_FULL        = 25600;

    localparam int unsigned NUM_W  = 24;
    localparam int unsigned REC_W  = 24;
    localparam int unsigned QUOT_W = 16;

    localparam int unsigned FRONT_STAGES = 2;
    localparam int unsigned DIV_STAGES   = 5;
    localparam int unsigned PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;
    localparam int unsigned OUT_STAGE    = PIPE_STAGES - 1;

    localparam logic [1:0] SECT_RED      = 2'd0;
    localparam logic [1:0] SECT_RED_WRAP = 2'd1;
    localparam logic [1:0] SECT_GREEN    = 2'd2;
    localparam logic [1:0] SECT_BLUE     = 2'd3;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
        logic [ALPHA_W-1:0]      alpha;
    } pixel_in_t;

    typedef struct packed {
        logic [FIELD_W-1:0] hue;
        logic [FIELD_W-1:0] saturation;
        logic [FIELD_W-1:0] lightness;
        logic [ALPHA_W-1:0] alpha_out;
    } pixel_out_t;

    typedef struct packed {
        logic [T_W-1:0]          t;
        logic [CHANNEL_BITS-1:0] d;
        logic [CHANNEL_BITS-1:0] den;
        logic [SUM_W-1:0]        sum;
        logic                    grey;
        logic [ALPHA_W-1:0]      alpha;
    } front_t;

    typedef struct packed {
        logic               grey;
        logic [ALPHA_W-1:0] alpha;
    } side_t;

endpackage

`default_nettype wire

// ----- src/rhc_front.sv -----
// Front end of the converter: max/min, hue sector, sum, difference, hue term.
// Two register stages. Depends on rhc_pkg.
`default_nettype none

module rhc_front (
    input  wire logic                                clk,
    input  wire logic [rhc_pkg::FRONT_STAGES-1:0]    en,
    input  wire rhc_pkg::pixel_in_t                  pixel,
    output rhc_pkg::front_t                          front
);

    logic [rhc_pkg::CHANNEL_BITS-1:0]        mx_reg, mx_next;
    logic [rhc_pkg::CHANNEL_BITS-1:0]        mn_reg, mn_next;
    logic [1:0]                              sect_reg, sect_next;
    logic signed [rhc_pkg::CHANNEL_BITS:0]   diff_reg, diff_next;
    logic [rhc_pkg::ALPHA_W-1:0]             alpha_reg;
    rhc_pkg::front_t                         front_reg, front_next;

    logic                                    r_max, g_max;
    logic [rhc_pkg::CHANNEL_BITS-1:0]        d_cur;
    logic [rhc_pkg::SUM_W-1:0]               sum_cur;
    logic [rhc_pkg::T_W-1:0]                 kd;
    logic signed [rhc_pkg::T_W:0]            t_full;

    assign r_max = (pixel.red >= pixel.green) && (pixel.red >= pixel.blue);
    assign g_max = !r_max && (pixel.green >= pixel.blue);

    always_comb
    begin
        mn_next = pixel.red;
        if (pixel.green < mn_next)
        begin
            mn_next = pixel.green;
        end
        if (pixel.blue < mn_next)
        begin
            mn_next = pixel.blue;
        end
        if (r_max)
        begin
            mx_next   = pixel.red;
            sect_next = (pixel.green < pixel.blue) ? rhc_pkg::SECT_RED_WRAP
                                                   : rhc_pkg::SECT_RED;
            diff_next = $signed({1'b0, pixel.green}) - $signed({1'b0, pixel.blue});
        end
        else if (g_max)
        begin
            mx_next   = pixel.green;
            sect_next = rhc_pkg::SECT_GREEN;
            diff_next = $signed({1'b0, pixel.blue}) - $signed({1'b0, pixel.red});
        end
        else
        begin
            mx_next   = pixel.blue;
            sect_next = rhc_pkg::SECT_BLUE;
            diff_next = $signed({1'b0, pixel.red}) - $signed({1'b0, pixel.green});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mx_reg    <= mx_next;
            mn_reg    <= mn_next;
            sect_reg  <= sect_next;
            diff_reg  <= diff_next;
            alpha_reg <= pixel.alpha;
        end
    end

    assign d_cur   = mx_reg - mn_reg;
    assign sum_cur = {1'b0, mx_reg} + {1'b0, mn_reg};

    always_comb
    begin
        unique case (sect_reg)
            rhc_pkg::SECT_RED:      kd = '0;
            rhc_pkg::SECT_RED_WRAP: kd = rhc_pkg::T_W'({d_cur, 2'b00})
                                       + rhc_pkg::T_W'({d_cur, 1'b0});
            rhc_pkg::SECT_GREEN:    kd = rhc_pkg::T_W'({d_cur, 1'b0});
            rhc_pkg::SECT_BLUE:     kd = rhc_pkg::T_W'({d_cur, 2'b00});
            default:                kd = '0;
        endcase
        t_full = $signed({1'b0, kd}) + (rhc_pkg::T_W + 1)'(diff_reg);

        front_next.t     = t_full[rhc_pkg::T_W-1:0];
        front_next.d     = d_cur;
        front_next.sum   = sum_cur;
        front_next.grey  = (d_cur == '0);
        front_next.alpha = alpha_reg;
        if (sum_cur > rhc_pkg::SUM_W'(rhc_pkg::CH_FULL))
        begin
            front_next.den = rhc_pkg::CHANNEL_BITS'(
                rhc_pkg::SUM_W'(2 * rhc_pkg::CH_FULL) - sum_cur);
        end
        else
        begin
            front_next.den = rhc_pkg::CHANNEL_BITS'(sum_cur);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            front_reg <= front_next;
        end
    end

    assign front = front_reg;

endmodule

`default_nettype wire

// ----- src/rhc_recip_div.sv -----
// Pipelined rounding divider: quot = floor(num / (2*divisor)).
// Reciprocal table, split multiply, one correction step. Depends on rhc_pkg.
`default_nettype none

module rhc_recip_div (
    input  wire logic                                clk,
    input  wire logic [rhc_pkg::DIV_STAGES-1:0]      en,
    input  wire logic [rhc_pkg::NUM_W-1:0]           num,
    input  wire logic [rhc_pkg::CHANNEL_BITS-1:0]    divisor,
    output logic      [rhc_pkg::QUOT_W-1:0]          quot
);

    localparam int unsigned HALF_W    = rhc_pkg::NUM_W / 2;
    localparam int unsigned PART_W    = HALF_W + rhc_pkg::REC_W;
    localparam int unsigned PROD_W    = rhc_pkg::NUM_W + rhc_pkg::REC_W;
    localparam int unsigned MUL_W     = rhc_pkg::QUOT_W + rhc_pkg::CHANNEL_BITS + 1;
    localparam int unsigned TAB_DEPTH = 1 << rhc_pkg::CHANNEL_BITS;
    localparam longint unsigned RECIP_ONE = 64'd1 << (rhc_pkg::NUM_W - 1);

    // floor(2^(NUM_W-1) / D); zero divisor only occurs for grey pixels
    logic [rhc_pkg::REC_W-1:0] recip_tab [TAB_DEPTH];

    for (genvar i = 0; i < TAB_DEPTH; i++)
    begin : g_recip
        localparam longint unsigned Divisor = (i == 0) ? 1 : i;
        localparam logic [rhc_pkg::REC_W-1:0] RECIP_VAL =
            (i == 0) ? '0 : rhc_pkg::REC_W'(RECIP_ONE / Divisor);
        assign recip_tab[i] = RECIP_VAL;
    end

    logic [rhc_pkg::NUM_W-1:0]        n1_reg, n2_reg, n3_reg, n4_reg;
    logic [rhc_pkg::CHANNEL_BITS-1:0] d1_reg, d2_reg, d3_reg, d4_reg;
    logic [rhc_pkg::REC_W-1:0]        r1_reg;
    logic [PART_W-1:0]                ph_reg, pl_reg;
    logic [rhc_pkg::QUOT_W-1:0]       q3_reg, q4_reg, q5_reg;
    logic [MUL_W-1:0]                 m4_reg;

    logic [PROD_W-1:0]                prod;
    logic [rhc_pkg::NUM_W-1:0]        rem;
    logic [rhc_pkg::QUOT_W-1:0]       q5_next;

    assign prod = {ph_reg, {HALF_W{1'b0}}} + PROD_W'(pl_reg);

    always_comb
    begin
        rem     = n4_reg - rhc_pkg::NUM_W'(m4_reg);
        q5_next = q4_reg
                + rhc_pkg::QUOT_W'(rem >= rhc_pkg::NUM_W'({d4_reg, 1'b0}));
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            n1_reg <= num;
            d1_reg <= divisor;
            r1_reg <= recip_tab[divisor];
        end
        if (en[1])
        begin
            ph_reg <= PART_W'(n1_reg[rhc_pkg::NUM_W-1:HALF_W]) * PART_W'(r1_reg);
            pl_reg <= PART_W'(n1_reg[HALF_W-1:0]) * PART_W'(r1_reg);
            n2_reg <= n1_reg;
            d2_reg <= d1_reg;
        end
        if (en[2])
        begin
            q3_reg <= prod[rhc_pkg::NUM_W +: rhc_pkg::QUOT_W];
            n3_reg <= n2_reg;
            d3_reg <= d2_reg;
        end
        if (en[3])
        begin
            m4_reg <= MUL_W'(q3_reg) * MUL_W'({d3_reg, 1'b0});
            q4_reg <= q3_reg;
            n4_reg <= n3_reg;
            d4_reg <= d3_reg;
        end
        if (en[4])
        begin
            q5_reg <= q5_next;
        end
    end

    assign quot = q5_reg;

endmodule

`default_nettype wire

// ----- src/rgb_to_hsl_converter.sv -----
// Top level of the RGB to HSL converter: handshake control, dividers, output stage.
// Depends on rhc_pkg, rhc_front, rhc_recip_div and rgb_to_hsl_converter_defines.svh.
`default_nettype none
`include "rgb_to_hsl_converter_defines.svh"

// Converts one RGBA pixel per clock into hue (1/64 degree), saturation and
// lightness (1/256 percent) with alpha passed through. From acceptance to
// result_valid a pixel passes two front-end stages (max/min, sector and hue
// term), five stages of reciprocal-table dividers for the three quotients,
// and the output register. Throughput is one item per cycle; each stage holds
// while it is full and the next one holds, so a stalled output only blocks
// input once every stage is occupied.
module rgb_to_hsl_converter (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pixel_valid,
    output logic                     pixel_ready,
    input  wire rhc_pkg::pixel_in_t  pixel,
    output logic                     result_valid,
    input  wire logic                result_ready,
    output rhc_pkg::pixel_out_t      result
);

    logic [rhc_pkg::PIPE_STAGES-1:0]  v_reg;
    logic [rhc_pkg::PIPE_STAGES-1:0]  en;

    rhc_pkg::front_t                  front;
    logic [rhc_pkg::NUM_W-1:0]        num_hue, num_sat, num_light;
    logic [rhc_pkg::QUOT_W-1:0]       q_hue, q_sat, q_light, hue_wrap;
    rhc_pkg::side_t                   side_reg [rhc_pkg::DIV_STAGES];
    rhc_pkg::pixel_out_t              result_reg, result_next;

    always_comb
    begin
        en[rhc_pkg::OUT_STAGE] = !v_reg[rhc_pkg::OUT_STAGE] || result_ready;
        for (int i = rhc_pkg::OUT_STAGE - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= pixel_valid;
            end
            for (int i = 1; i < rhc_pkg::PIPE_STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    rhc_front u_front (
        .clk   (clk),
        .en    (en[rhc_pkg::FRONT_STAGES-1:0]),
        .pixel (pixel),
        .front (front)
    );

    assign num_hue   = rhc_pkg::NUM_W'(front.t) * rhc_pkg::NUM_W'(rhc_pkg::HUE_NUM_SCALE)
                     + rhc_pkg::NUM_W'(front.d);
    assign num_sat   = rhc_pkg::NUM_W'(front.d) * rhc_pkg::NUM_W'(rhc_pkg::SAT_NUM_SCALE)
                     + rhc_pkg::NUM_W'(front.den);
    assign num_light = rhc_pkg::NUM_W'(front.sum)
                     * rhc_pkg::NUM_W'(rhc_pkg::LIGHT_NUM_SCALE)
                     + rhc_pkg::NUM_W'(rhc_pkg::CH_FULL);

    rhc_recip_div u_div_hue (
        .clk     (clk),
        .en      (en[rhc_pkg::FRONT_STAGES +: rhc_pkg::DIV_STAGES]),
        .num     (num_hue),
        .divisor (front.d),
        .quot    (q_hue)
    );

    rhc_recip_div u_div_sat (
        .clk     (clk),
        .en      (en[rhc_pkg::FRONT_STAGES +: rhc_pkg::DIV_STAGES]),
        .num     (num_sat),
        .divisor (front.den),
        .quot    (q_sat)
    );

    rhc_recip_div u_div_light (
        .clk     (clk),
        .en      (en[rhc_pkg::FRONT_STAGES +: rhc_pkg::DIV_STAGES]),
        .num     (num_light),
        .divisor (rhc_pkg::CHANNEL_BITS'(rhc_pkg::CH_FULL)),
        .quot    (q_light)
    );

    always_ff @(posedge clk)
    begin
        if (en[rhc_pkg::FRONT_STAGES])
        begin
            side_reg[0] <= '{grey: front.grey, alpha: front.alpha};
        end
        for (int i = 1; i < rhc_pkg::DIV_STAGES; i++)
        begin
            if (en[rhc_pkg::FRONT_STAGES + i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (q_hue >= rhc_pkg::QUOT_W'(rhc_pkg::HUE_TURN))
        begin
            hue_wrap = q_hue - rhc_pkg::QUOT_W'(rhc_pkg::HUE_TURN);
        end
        else
        begin
            hue_wrap = q_hue;
        end
        result_next.lightness = rhc_pkg::FIELD_W'(q_light);
        result_next.alpha_out = side_reg[rhc_pkg::DIV_STAGES-1].alpha;
        if (side_reg[rhc_pkg::DIV_STAGES-1].grey)
        begin
            result_next.hue        = '0;
            result_next.saturation = '0;
        end
        else
        begin
            result_next.hue        = rhc_pkg::FIELD_W'(hue_wrap);
            result_next.saturation = rhc_pkg::FIELD_W'(q_sat);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[rhc_pkg::OUT_STAGE])
        begin
            result_reg <= result_next;
        end
    end

    assign pixel_ready  = en[0];
    assign result_valid = v_reg[rhc_pkg::OUT_STAGE];
    assign result       = result_reg;

    `RHC_ASSERT_NOW(a_grey_hue, result_valid && (result.saturation == '0),
        result.hue == '0, "zero saturation with nonzero hue")
    `RHC_ASSERT_NOW(a_hue_range, result_valid,
        result.hue < rhc_pkg::FIELD_W'(rhc_pkg::HUE_TURN), "hue not below a full turn")
    `RHC_ASSERT_NOW(a_pct_range, result_valid,
        (result.saturation <= rhc_pkg::FIELD_W'(rhc_pkg::PCT_FULL))
        && (result.lightness <= rhc_pkg::FIELD_W'(rhc_pkg::PCT_FULL)),
        "saturation or lightness above full scale")
    `RHC_ASSERT_NOW(a_full_stall, !pixel_ready,
        result_valid && !result_ready && (v_reg == '1), "input blocked with room in pipeline")
    `RHC_ASSERT_NEXT(a_drain, result_valid && result_ready && !v_reg[rhc_pkg::OUT_STAGE-1],
        !result_valid, "result repeated after hand-off")

endmodule

`default_nettype wire
